@@ rtl/bds_pkg.sv @@
package bds_pkg;

	// channel and sum widths
	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 4;
	localparam int SUM_W    = CHAN_W + 1;
	localparam int PIX_W    = CHAN_W * NUM_CHAN;
	localparam int PAIR_W   = SUM_W * NUM_CHAN;

	// frame geometry
	localparam int DIM_W          = 13;
	localparam int ROW_W          = 12;
	localparam int MIN_DIM        = 2;
	localparam int MAX_SRC_HEIGHT = 4096;

	// configuration register indexes
	localparam int          CFG_IDX_W      = 2;
	localparam logic [1:0]  REG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0]  REG_SRC_HEIGHT = 2'd1;

	localparam logic [DIM_W-1:0] DIM_RESET = 13'd512;

	// what the current source position does
	typedef struct packed {
		logic hold;   // even column: keep pixel as left of pair
		logic wr;     // even row, odd column: store pair sum in line
		logic emit;   // odd row, odd column: block complete
		logic last;   // last block of the output frame
	} pos_info_t;

	typedef logic [PIX_W-1:0]  pixel_t;
	typedef logic [PAIR_W-1:0] pair_t;

	// horizontal pair sum of two pixels, red in the low bits
	function automatic pair_t pair_sum(input pixel_t a, input pixel_t b);
		pair_t s;
		s = '0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			s[c*SUM_W +: SUM_W] = SUM_W'(a[c*CHAN_W +: CHAN_W]) + SUM_W'(b[c*CHAN_W +: CHAN_W]);
		end
		return s;
	endfunction

endpackage

@@ rtl/bds_line_ram.sv @@
module bds_line_ram #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [bds_pkg::PAIR_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [bds_pkg::PAIR_W-1:0] rd_data
);

	logic [bds_pkg::PAIR_W-1:0] mem_q [DEPTH];
	logic [bds_pkg::PAIR_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/bds_pos_ctr.sv @@
module bds_pos_ctr #(
	parameter int MAX_SRC_WIDTH = 4096,
	parameter int AW            = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [bds_pkg::DIM_W-1:0]  src_width,
	input  logic [bds_pkg::DIM_W-1:0]  src_height,
	input  logic                       advance,
	output logic [AW-1:0]              slot,
	output bds_pkg::pos_info_t         info
);

	localparam int CW   = $clog2(MAX_SRC_WIDTH);
	localparam int WW   = $clog2(MAX_SRC_WIDTH + 1);
	localparam int CMPW = (WW > bds_pkg::DIM_W) ? WW : bds_pkg::DIM_W;
	localparam int RW   = bds_pkg::ROW_W;
	localparam int HW   = bds_pkg::DIM_W;

	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;

	logic [CMPW-1:0] w_raw;
	logic [CMPW-1:0] w_cl;
	logic [WW-1:0]   w_eff;
	logic [HW-1:0]   h_eff;
	logic            wrap_pre;
	logic [RW:0]     row_pre;
	logic [CW-1:0]   col_cur;
	logic [RW-1:0]   row_cur;
	logic [WW-1:0]   col_inc;
	logic [RW:0]     row_inc;
	logic [CW-1:0]   col_n;
	logic [RW-1:0]   row_n;

	// clamp the frame size to the supported range
	always_comb begin
		w_raw = CMPW'(src_width);
		if (w_raw < CMPW'(bds_pkg::MIN_DIM)) begin
			w_cl = CMPW'(bds_pkg::MIN_DIM);
		end else if (w_raw > CMPW'(MAX_SRC_WIDTH)) begin
			w_cl = CMPW'(MAX_SRC_WIDTH);
		end else begin
			w_cl = w_raw;
		end
		w_eff = w_cl[WW-1:0];
		if (src_height < HW'(bds_pkg::MIN_DIM)) begin
			h_eff = HW'(bds_pkg::MIN_DIM);
		end else if (src_height > HW'(bds_pkg::MAX_SRC_HEIGHT)) begin
			h_eff = HW'(bds_pkg::MAX_SRC_HEIGHT);
		end else begin
			h_eff = src_height;
		end
	end

	// current position, wrapped if the size shrank since the last word
	always_comb begin
		wrap_pre = WW'(col_q) >= w_eff;
		row_pre  = wrap_pre ? ({1'b0, row_q} + 1'b1) : {1'b0, row_q};
		col_cur  = wrap_pre ? '0 : col_q;
		row_cur  = (row_pre >= HW'(row_pre) && HW'(row_pre) >= h_eff) ? '0 : row_pre[RW-1:0];
	end

	// next position
	always_comb begin
		col_inc = WW'(col_cur) + 1'b1;
		row_inc = {1'b0, row_cur} + 1'b1;
		if (col_inc >= w_eff) begin
			col_n = '0;
			row_n = (HW'(row_inc) >= h_eff) ? '0 : row_inc[RW-1:0];
		end else begin
			col_n = col_inc[CW-1:0];
			row_n = row_cur;
		end
	end

	// position decode
	always_comb begin
		info.hold = ~col_cur[0];
		info.wr   = col_cur[0] & ~row_cur[0];
		info.emit = col_cur[0] & row_cur[0];
		info.last = (col_inc == {w_eff[WW-1:1], 1'b0})
			&& (HW'(row_inc) == {h_eff[HW-1:1], 1'b0});
		slot      = col_cur[AW:1];
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			col_q <= col_n;
			row_q <= row_n;
		end
	end

endmodule

@@ rtl/bds_avg_out.sv @@
module bds_avg_out (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  bds_pkg::pair_t         pair_below,
	input  bds_pkg::pair_t         pair_above,
	input  logic                   in_last,
	output logic                   in_take,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [31:0]            m_tdata,   // out_red, out_green, out_blue, out_alpha
	output logic                   m_tlast    // frame_last
);

	localparam int CW = bds_pkg::CHAN_W;
	localparam int SW = bds_pkg::SUM_W;

	logic                  valid_q;
	bds_pkg::pixel_t       data_q;
	logic                  last_q;
	bds_pkg::pixel_t       avg;
	logic [SW:0]           tot;

	// four-pixel sum >> 2; a 10-bit sum shifted by two never exceeds 255
	always_comb begin
		avg = '0;
		tot = '0;
		for (int c = 0; c < bds_pkg::NUM_CHAN; c++) begin
			tot = {1'b0, pair_below[c*SW +: SW]} + {1'b0, pair_above[c*SW +: SW]};
			avg[c*CW +: CW] = tot[SW:2];
		end
	end

	assign in_take = ~valid_q | m_tready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_take) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && in_valid) begin
			data_q <= avg;
			last_q <= in_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

endmodule

@@ rtl/box_downsample_2x2_rgba8.sv @@
// 2x2 box downsampler for RGBA8 raster video. Source pixels enter in raster order; each
// 2x2 block yields one pixel, sent after the block's bottom-right pixel, with each
// channel the four-pixel sum shifted right by two. tlast marks the last pixel of the
// output frame; a trailing odd column or row is dropped. Sustained rate is one source
// pixel per clock while m_tready holds; a result passes the line memory read register,
// then the output register. Pair sums of even rows live in an internal line memory of
// MAX_SRC_WIDTH/2 entries of 36 bits with one write and one read port; it needs no
// clearing after reset. The user must write src_width and src_height (2..4096, width
// also capped at MAX_SRC_WIDTH) between frames; the block does not enforce it.
module box_downsample_2x2_rgba8 #(
	parameter int MAX_SRC_WIDTH = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [bds_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bds_pkg::DIM_W-1:0]       cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [31:0]                     s_tdata,   // pixel_red, pixel_green, pixel_blue, pixel_alpha
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [31:0]                     m_tdata,   // out_red, out_green, out_blue, out_alpha
	output logic                            m_tlast    // frame_last
);

	localparam int LINE_DEPTH = MAX_SRC_WIDTH / 2;
	localparam int AW         = $clog2(LINE_DEPTH);

	logic [bds_pkg::DIM_W-1:0] src_width_q;
	logic [bds_pkg::DIM_W-1:0] src_height_q;
	bds_pkg::pixel_t           left_q;
	logic                      s1_valid_q;
	bds_pkg::pair_t            pair_s1;
	logic                      last_s1;

	logic                      accept;
	logic                      out_take;
	logic [AW-1:0]             slot;
	bds_pkg::pos_info_t        info;
	bds_pkg::pair_t            pair;
	bds_pkg::pair_t            above;
	logic                      mem_wr;
	logic                      mem_rd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= bds_pkg::DIM_RESET;
			src_height_q <= bds_pkg::DIM_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				bds_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_wdata;
				bds_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input handshake: stall only when both result stages are full
	assign s_tready = ~s1_valid_q | out_take;
	assign accept   = s_tvalid & s_tready;

	bds_pos_ctr #(
		.MAX_SRC_WIDTH (MAX_SRC_WIDTH),
		.AW            (AW)
	) u_pos (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_width  (src_width_q),
		.src_height (src_height_q),
		.advance    (accept),
		.slot       (slot),
		.info       (info)
	);

	// horizontal pair sum with the held left pixel
	assign pair   = bds_pkg::pair_sum(left_q, s_tdata);
	assign mem_wr = accept & info.wr;
	assign mem_rd = accept & info.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (accept && info.hold) begin
			left_q <= s_tdata;
		end
	end

	bds_line_ram #(
		.DEPTH (LINE_DEPTH),
		.AW    (AW)
	) u_line (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (slot),
		.wr_data (pair),
		.rd_en   (mem_rd),
		.rd_addr (slot),
		.rd_data (above)
	);

	// stage 1: bottom pair sum waits beside the line read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (mem_rd) begin
			s1_valid_q <= 1'b1;
		end else if (out_take) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_rd) begin
			pair_s1 <= pair;
			last_s1 <= info.last;
		end
	end

	bds_avg_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s1_valid_q),
		.pair_below (pair_s1),
		.pair_above (above),
		.in_last    (last_s1),
		.in_take    (out_take),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

	// input stalls only when stage 1 and the output word are both held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_valid_q && m_tvalid && !m_tready))
		else $error("input stalled without a full pipeline");

	// a line entry is never written and read in the same cycle
	a_mem_excl: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr |-> !mem_rd)
		else $error("line write and read collide");

	// a completed block always lands in stage 1
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		mem_rd |=> s1_valid_q)
		else $error("completed block lost before stage 1");

	// a held stage 1 word keeps its pair sum
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !out_take) |=> (s1_valid_q && $stable(pair_s1)))
		else $error("stage 1 word changed while stalled");

endmodule
